### sv/jdm_pkg.sv
package jdm_pkg;

  localparam int unsigned CORDIC_STEPS = 32;
  localparam int unsigned DIV_STEPS    = 14;
  localparam int unsigned ROOT_STEPS   = 7;
  localparam int unsigned SPD_STEPS    = 24;

  localparam logic [15:0] SCALE_RESET = 16'd256;

  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef struct packed {
    logic sx;
    logic sy;
    logic zero;
  } flags_t;

endpackage

### sv/joystick_disc_map_polar_top.sv
// Joystick square-to-disc mapper with heading and speed.
// Input channel: raw_x, raw_y with in_valid / in_stall; a sample transfers
// on a rising edge with in_valid high and in_stall low.
// Output channel: disc_x, disc_y, heading, speed with out_valid / out_stall.
// Configuration: speed_scale written through cfg_valid / cfg_ready; cfg_ready
// is always high. Write it only while no sample is in flight.
// From input transfer to out_valid a sample passes 3 set-up stages,
// a 14-stage restoring divider, a 7-stage square root, one sign stage, and
// a 33-stage CORDIC vectoring pipeline (the speed root runs alongside it),
// then the output register. Throughput is one sample per cycle when not stalled.
// The whole pipeline advances together; when out_valid is high and the
// receiver stalls, every stage holds and in_stall goes high until the
// waiting result transfers.
// Reset clears all valid bits and sets speed_scale to 1.0 (256).
module joystick_disc_map_polar_top #(
  parameter int ANGLE_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        raw_x,
  input  logic [7:0]        raw_y,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [7:0] disc_x,
  output logic signed [7:0] disc_y,
  output logic [15:0]       heading,
  output logic [14:0]       speed,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [15:0]       speed_scale
);

  localparam int DN  = int'(jdm_pkg::DIV_STEPS);
  localparam int RN  = int'(jdm_pkg::ROOT_STEPS);
  localparam int CN  = int'(jdm_pkg::CORDIC_STEPS);
  localparam int SN  = int'(jdm_pkg::SPD_STEPS);
  localparam int LAT = 3 + DN + RN + 1 + 1 + CN + 1;
  localparam int SH  = 32 - ANGLE_BITS;

  logic           en;
  logic [LAT-1:0] vld;
  logic [15:0]    scale;
  logic [31:0]    s2;

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      scale <= jdm_pkg::SCALE_RESET;
      s2    <= 32'd65536;
    end else begin
      if (en) vld <= {vld[LAT-2:0], in_valid};
      if (cfg_valid && cfg_ready) scale <= speed_scale;
      s2 <= 32'(scale) * 32'(scale);
    end
  end

  // centre and clamp
  logic       s1_sx, s1_sy;
  logic [6:0] s1_ax, s1_ay, s1_m;
  logic [7:0] cx, cy;
  logic [6:0] ax_c, ay_c;

  always_comb begin
    cx   = {~raw_x[7], raw_x[6:0]};
    cy   = {raw_y[7], ~raw_y[6:0]};
    ax_c = cx[7] ? 7'(~cx + 8'd1) : cx[6:0];
    ay_c = cy[7] ? 7'(~cy + 8'd1) : cy[6:0];
    if (cx == 8'h80) ax_c = 7'd127;
    if (cy == 8'h80) ay_c = 7'd127;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sx <= cx[7];
      s1_sy <= cy[7];
      s1_ax <= ax_c;
      s1_ay <= ay_c;
      s1_m  <= (ax_c > ay_c) ? ax_c : ay_c;
    end
  end

  logic [13:0]     s2_ax2, s2_ay2, s2_m2;
  jdm_pkg::flags_t s2_fl;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ax2 <= 14'(s1_ax) * 14'(s1_ax);
      s2_ay2 <= 14'(s1_ay) * 14'(s1_ay);
      s2_m2  <= 14'(s1_m) * 14'(s1_m);
      s2_fl  <= '{sx: s1_sx, sy: s1_sy, zero: (s1_ax == 7'd0) && (s1_ay == 7'd0)};
    end
  end

  // divider: index 0 holds the numerators and divisor
  logic [27:0]     drx [0:DN];
  logic [27:0]     dry [0:DN];
  logic [13:0]     dqx [0:DN];
  logic [13:0]     dqy [0:DN];
  logic [14:0]     dr2 [0:DN];
  jdm_pkg::flags_t dfl [0:DN];

  always_ff @(posedge clk) begin
    if (en) begin
      drx[0] <= 28'(s2_ax2) * 28'(s2_m2);
      dry[0] <= 28'(s2_ay2) * 28'(s2_m2);
      dqx[0] <= '0;
      dqy[0] <= '0;
      dr2[0] <= 15'(s2_ax2) + 15'(s2_ay2);
      dfl[0] <= s2_fl;
    end
  end

  for (genvar j = 1; j <= DN; j++) begin : g_div
    logic [28:0] dsh;
    assign dsh = 29'(dr2[j-1]) << (DN - j);
    always_ff @(posedge clk) begin
      if (en) begin
        dr2[j] <= dr2[j-1];
        dfl[j] <= dfl[j-1];
        if ({1'b0, drx[j-1]} >= dsh) begin
          drx[j] <= drx[j-1] - dsh[27:0];
          dqx[j] <= {dqx[j-1][12:0], 1'b1};
        end else begin
          drx[j] <= drx[j-1];
          dqx[j] <= {dqx[j-1][12:0], 1'b0};
        end
        if ({1'b0, dry[j-1]} >= dsh) begin
          dry[j] <= dry[j-1] - dsh[27:0];
          dqy[j] <= {dqy[j-1][12:0], 1'b1};
        end else begin
          dry[j] <= dry[j-1];
          dqy[j] <= {dqy[j-1][12:0], 1'b0};
        end
      end
    end
  end

  // square root of the quotients, two bits a stage
  logic [13:0]     qpx [1:RN];
  logic [13:0]     qpy [1:RN];
  logic [8:0]      qmx [1:RN];
  logic [8:0]      qmy [1:RN];
  logic [6:0]      qrx [1:RN];
  logic [6:0]      qry [1:RN];
  jdm_pkg::flags_t qfl [1:RN];

  for (genvar j = 1; j <= RN; j++) begin : g_root
    logic [13:0]     px, py;
    logic [8:0]      mx, my;
    logic [6:0]      rx, ry;
    jdm_pkg::flags_t fl;
    logic [10:0]     r2x, r2y, tx, ty;
    if (j == 1) begin : g_first
      assign px = dqx[DN];
      assign py = dqy[DN];
      assign mx = '0;
      assign my = '0;
      assign rx = '0;
      assign ry = '0;
      assign fl = dfl[DN];
    end else begin : g_next
      assign px = qpx[j-1];
      assign py = qpy[j-1];
      assign mx = qmx[j-1];
      assign my = qmy[j-1];
      assign rx = qrx[j-1];
      assign ry = qry[j-1];
      assign fl = qfl[j-1];
    end
    assign r2x = {mx, px[13:12]};
    assign r2y = {my, py[13:12]};
    assign tx  = {2'b00, rx, 2'b01};
    assign ty  = {2'b00, ry, 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        qpx[j] <= {px[11:0], 2'b00};
        qpy[j] <= {py[11:0], 2'b00};
        qfl[j] <= fl;
        if (r2x >= tx) begin
          qmx[j] <= 9'(r2x - tx);
          qrx[j] <= {rx[5:0], 1'b1};
        end else begin
          qmx[j] <= r2x[8:0];
          qrx[j] <= {rx[5:0], 1'b0};
        end
        if (r2y >= ty) begin
          qmy[j] <= 9'(r2y - ty);
          qry[j] <= {ry[5:0], 1'b1};
        end else begin
          qmy[j] <= r2y[8:0];
          qry[j] <= {ry[5:0], 1'b0};
        end
      end
    end
  end

  // apply signs, force the centre sample to zero
  logic signed [7:0] dx_r, dy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (qfl[RN].zero) begin
        dx_r <= '0;
        dy_r <= '0;
      end else begin
        dx_r <= qfl[RN].sx ? -$signed({1'b0, qrx[RN]}) : $signed({1'b0, qrx[RN]});
        dy_r <= qfl[RN].sy ? -$signed({1'b0, qry[RN]}) : $signed({1'b0, qry[RN]});
      end
    end
  end

  // CORDIC vectoring with speed root alongside
  logic signed [31:0] ca  [0:CN];
  logic signed [31:0] cb  [0:CN];
  logic [31:0]        cac [0:CN];
  logic signed [7:0]  cdx [0:CN];
  logic signed [7:0]  cdy [0:CN];
  logic [14:0]        cr2;
  logic [47:0]        sp  [1:CN];
  logic [25:0]        sm  [1:CN];
  logic [23:0]        sr  [1:CN];
  logic signed [31:0] a0, b0;
  logic signed [15:0] pdx, pdy;

  assign a0  = {{4{dy_r[7]}}, dy_r, 20'd0};
  assign b0  = {{4{dx_r[7]}}, dx_r, 20'd0};
  assign pdx = dx_r * dx_r;
  assign pdy = dy_r * dy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      cdx[0] <= dx_r;
      cdy[0] <= dy_r;
      cr2    <= 15'(pdx + pdy);
      if (dy_r[7]) begin
        ca[0]  <= -a0;
        cb[0]  <= -b0;
        cac[0] <= 32'h8000_0000;
      end else begin
        ca[0]  <= a0;
        cb[0]  <= b0;
        cac[0] <= '0;
      end
    end
  end

  for (genvar k = 1; k <= CN; k++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (en) begin
        cdx[k] <= cdx[k-1];
        cdy[k] <= cdy[k-1];
        if (cb[k-1] > 0) begin
          ca[k]  <= ca[k-1] + (cb[k-1] >>> (k - 1));
          cb[k]  <= cb[k-1] - (ca[k-1] >>> (k - 1));
          cac[k] <= cac[k-1] + jdm_pkg::ATAN_TAB[k-1];
        end else begin
          ca[k]  <= ca[k-1] - (cb[k-1] >>> (k - 1));
          cb[k]  <= cb[k-1] + (ca[k-1] >>> (k - 1));
          cac[k] <= cac[k-1] - jdm_pkg::ATAN_TAB[k-1];
        end
      end
    end

    if (k == 1) begin : g_prod
      always_ff @(posedge clk) begin
        if (en) begin
          sp[k] <= 48'(s2) * 48'(cr2);
          sm[k] <= '0;
          sr[k] <= '0;
        end
      end
    end else if (k <= SN + 1) begin : g_sqrt
      logic [27:0] rem2, trial;
      assign rem2  = {sm[k-1], sp[k-1][47:46]};
      assign trial = {2'b00, sr[k-1], 2'b01};
      always_ff @(posedge clk) begin
        if (en) begin
          sp[k] <= {sp[k-1][45:0], 2'b00};
          if (rem2 >= trial) begin
            sm[k] <= 26'(rem2 - trial);
            sr[k] <= {sr[k-1][22:0], 1'b1};
          end else begin
            sm[k] <= rem2[25:0];
            sr[k] <= {sr[k-1][22:0], 1'b0};
          end
        end
      end
    end else begin : g_hold
      always_ff @(posedge clk) begin
        if (en) begin
          sp[k] <= sp[k-1];
          sm[k] <= sm[k-1];
          sr[k] <= sr[k-1];
        end
      end
    end
  end

  // round heading to the angle width
  logic [32:0] rsum, hsh;
  logic [15:0] hmask;

  always_comb begin
    rsum = {1'b0, cac[CN]} + (33'd1 << (SH - 1));
    hsh  = rsum >> SH;
    for (int i = 0; i < 16; i++) hmask[i] = (i < ANGLE_BITS) ? hsh[i] : 1'b0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      disc_x  <= cdx[CN];
      disc_y  <= cdy[CN];
      heading <= (cdx[CN] == 8'sd0 && cdy[CN] == 8'sd0) ? 16'd0 : hmask;
      speed   <= sr[CN][22:8];
    end
  end

  a_disc_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (disc_x != -8'sd128) && (disc_y != -8'sd128))
    else $error("disc coordinate out of range");

  a_origin: assert property (@(posedge clk) disable iff (rst)
    (out_valid && disc_x == 8'sd0 && disc_y == 8'sd0) |-> (heading == 16'd0 && speed == 15'd0))
    else $error("origin result not zero");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> vld[0])
    else $error("transfer lost at entry");

  a_scale_sq: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> ##1 (s2 == 32'($past(speed_scale, 2)) * 32'($past(speed_scale, 2))))
    else $error("scale square not updated");

endmodule

### bench/tb_joystick_disc_map_polar_top.sv
module tb_joystick_disc_map_polar_top;

  localparam int ANGLE_W  = 16;
  localparam int LATENCY  = 59;
  localparam int LIMIT    = 400000;
  localparam int PER_PHASE = 240;

  typedef struct packed {
    logic signed [7:0] dx;
    logic signed [7:0] dy;
    logic [15:0]       hdg;
    logic [14:0]       spd;
  } disc_point_t;

  typedef struct {
    logic [7:0]  rx;
    logic [7:0]  ry;
    bit          typed;
    disc_point_t pt;
  } sample_row_t;

  logic clk, rst;
  logic in_valid, in_stall;
  logic [7:0] raw_x, raw_y;
  logic out_valid, out_stall;
  logic signed [7:0] disc_x, disc_y;
  logic [15:0] heading;
  logic [14:0] speed;
  logic cfg_valid, cfg_ready;
  logic [15:0] speed_scale;

  disc_point_t disc_exp_q[$];
  logic [15:0] scale_reg;
  int errors, cycles, send_idle, stall_pct;
  bit running;

  joystick_disc_map_polar_top #(.ANGLE_BITS(ANGLE_W)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .raw_x(raw_x), .raw_y(raw_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .disc_x(disc_x), .disc_y(disc_y), .heading(heading), .speed(speed),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .speed_scale(speed_scale)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic int stretch_axis(int c, longint m, longint r2);
    longint unsigned mag, num;
    int q;
    mag = (c < 0) ? -c : c;
    num = mag * mag * m * m;
    q = int'(int_root(num / r2));
    return (c < 0) ? -q : q;
  endfunction

  function automatic logic [15:0] cordic_heading(int dx, int dy);
    longint a, b, na, nb;
    logic [31:0] acc;
    logic [32:0] rnd;
    a = longint'(dy) <<< 20;
    b = longint'(dx) <<< 20;
    acc = 0;
    if (a < 0) begin
      a = -a;
      b = -b;
      acc = 32'h8000_0000;
    end
    for (int i = 0; i < 32; i++) begin
      if (b > 0) begin
        na = a + (b >>> i);
        nb = b - (a >>> i);
        acc += jdm_pkg::ATAN_TAB[i];
      end else begin
        na = a - (b >>> i);
        nb = b + (a >>> i);
        acc -= jdm_pkg::ATAN_TAB[i];
      end
      a = na;
      b = nb;
    end
    rnd = ({1'b0, acc} + (33'd1 << (32 - ANGLE_W - 1))) >> (32 - ANGLE_W);
    return rnd[15:0];
  endfunction

  function automatic disc_point_t predict_disc(logic [7:0] rx, logic [7:0] ry,
                                               logic [15:0] sc);
    int x, y, dx, dy;
    longint ax, ay, m, r2;
    longint unsigned dr2, s2;
    disc_point_t p;
    x = int'(rx) - 128;
    y = 127 - int'(ry);
    if (x == -128) x = -127;
    if (y == -128) y = -127;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    m = (ax > ay) ? ax : ay;
    r2 = longint'(x) * x + longint'(y) * y;
    p = '0;
    if (r2 == 0) return p;
    dx = stretch_axis(x, m, r2);
    dy = stretch_axis(y, m, r2);
    dr2 = longint'(dx) * dx + longint'(dy) * dy;
    s2 = longint'(sc) * longint'(sc);
    p.dx = dx[7:0];
    p.dy = dy[7:0];
    p.hdg = (dx == 0 && dy == 0) ? 16'd0 : cordic_heading(dx, dy);
    p.spd = 15'(int_root(s2 * dr2) >> 8);
    return p;
  endfunction

  task automatic send_sample(logic [7:0] rx, logic [7:0] ry, bit typed, disc_point_t pt);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    raw_x = rx;
    raw_y = ry;
    do @(posedge clk); while (in_stall);
    disc_exp_q.push_back(typed ? pt : predict_disc(rx, ry, scale_reg));
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic write_scale(logic [15:0] v);
    while (disc_exp_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    cfg_valid = 1;
    speed_scale = v;
    do @(posedge clk); while (!cfg_ready);
    scale_reg = v;
    @(negedge clk);
    cfg_valid = 0;
  endtask

  function automatic logic [7:0] pick_raw();
    logic [7:0] edges [8] = '{8'd0, 8'd1, 8'd126, 8'd127, 8'd128, 8'd129, 8'd254, 8'd255};
    if ($urandom_range(3) == 0) return edges[$urandom_range(7)];
    return 8'($urandom);
  endfunction

  always @(negedge clk) begin
    if (!rst) out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    disc_point_t e;
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("joystick_disc_map_polar_top regression: fail");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      if (disc_exp_q.size() == 0) begin
        $error("unexpected transfer: disc_x %0d disc_y %0d", disc_x, disc_y);
        errors++;
      end else begin
        e = disc_exp_q.pop_front();
        if (disc_x !== e.dx) begin
          $error("disc_x expected %0d actual %0d", e.dx, disc_x);
          errors++;
        end
        if (disc_y !== e.dy) begin
          $error("disc_y expected %0d actual %0d", e.dy, disc_y);
          errors++;
        end
        if (heading !== e.hdg) begin
          $error("heading expected %0d actual %0d", e.hdg, heading);
          errors++;
        end
        if (speed !== e.spd) begin
          $error("speed expected %0d actual %0d", e.spd, speed);
          errors++;
        end
      end
    end
  end

  initial begin
    sample_row_t rows [14];
    logic [15:0] scales [6];
    int idle_tab [4];
    int stall_tab [4];
    rows = '{
      '{8'd128, 8'd127, 1'b1, '0},
      '{8'd128, 8'd128, 1'b0, '0},
      '{8'd255, 8'd127, 1'b0, '0},
      '{8'd0,   8'd127, 1'b0, '0},
      '{8'd1,   8'd127, 1'b0, '0},
      '{8'd128, 8'd0,   1'b0, '0},
      '{8'd128, 8'd255, 1'b0, '0},
      '{8'd128, 8'd254, 1'b0, '0},
      '{8'd0,   8'd0,   1'b0, '0},
      '{8'd255, 8'd255, 1'b0, '0},
      '{8'd0,   8'd255, 1'b0, '0},
      '{8'd255, 8'd0,   1'b0, '0},
      '{8'd129, 8'd126, 1'b0, '0},
      '{8'd127, 8'd128, 1'b0, '0}
    };
    scales = '{16'd256, 16'd0, 16'hFFFF, 16'd1, 16'd0, 16'd256};
    idle_tab = '{0, 87, 0, 24};
    stall_tab = '{0, 0, 87, 24};
    scales[4] = 16'($urandom);
    errors = 0;
    cycles = 0;
    send_idle = 0;
    stall_pct = 0;
    scale_reg = jdm_pkg::SCALE_RESET;
    rst = 1;
    in_valid = 0;
    raw_x = 0;
    raw_y = 0;
    out_stall = 0;
    cfg_valid = 0;
    speed_scale = 0;
    repeat (2) @(negedge clk);
    rst = 0;
    foreach (rows[i]) send_sample(rows[i].rx, rows[i].ry, rows[i].typed, rows[i].pt);
    for (int p = 0; p < 6; p++) begin
      if (p != 0) write_scale(scales[p]);
      send_idle = idle_tab[p % 4];
      stall_pct = stall_tab[p % 4];
      for (int n = 0; n < PER_PHASE; n++) begin
        if (n == PER_PHASE / 2) begin
          send_idle = 0;
          stall_pct = 0;
        end
        send_sample(pick_raw(), pick_raw(), 1'b0, '0);
      end
    end
    while (disc_exp_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0) begin
      $display("joystick_disc_map_polar_top regression: pass");
    end else begin
      $display("joystick_disc_map_polar_top regression: fail");
    end
    $finish;
  end
endmodule

### joystick_disc_map_polar_top.f
sv/jdm_pkg.sv
sv/joystick_disc_map_polar_top.sv
bench/tb_joystick_disc_map_polar_top.sv
